/* hw/rtl/affine_transform_composer_assert.svh */
// ----------------------------------------------------------------------------
// Affine transform composer assertion macros
// Concurrent assertion wrappers that fall away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_COMPOSER_ASSERT_SVH
`define AFFINE_TRANSFORM_COMPOSER_ASSERT_SVH
`ifndef SYNTHESIS
`define ATC_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("affine_transform_composer assertion failed");
`define ATC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("affine_transform_composer assertion failed");
`else
`define ATC_ASSERT_SAME(label, clk, rst_n, pre, post)
`define ATC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* hw/rtl/atc_pkg.sv */
// ----------------------------------------------------------------------------
// Affine transform composer package
// Widths, codes, control structs, the arctangent table and the step program.
// ----------------------------------------------------------------------------
package atc_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int WORD_W   = 32;
    localparam int ANGLE_W  = 16;
    localparam int FUNC_W   = 2;
    localparam int ACC_W    = 64;
    localparam int CORD_W   = 36;
    localparam int ATAN_IW  = 5;
    localparam int STEP_W   = 4;
    localparam int IN_W     = 144;
    localparam int OUT_W    = 192;
    localparam int NUM_ENT  = 6;

    localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 36'sd652032875;
    localparam logic signed [CORD_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CORD_W-1:0] HALF_PI_Q30 = 36'sd1686629713;

    localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    typedef enum logic [1:0] {
        FUNC_TRANSLATE,
        FUNC_ROTATE,
        FUNC_SCALE,
        FUNC_IDENTITY
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        A_TX,
        A_TY,
        A_G00,
        A_G01,
        A_G10,
        A_G11
    } asel_t;

    typedef enum logic [3:0] {
        B_K0,
        B_K1,
        B_K2,
        B_M0,
        B_M1,
        B_M2,
        B_M3,
        B_M4,
        B_M5
    } bsel_t;

    typedef enum logic [2:0] {
        I_ZERO,
        I_TX,
        I_TY,
        I_G2,
        I_G5
    } init_t;

    typedef enum logic [2:0] {
        D_G2,
        D_G5,
        D_N0,
        D_N1,
        D_N2,
        D_N3,
        D_N4,
        D_N5
    } dst_t;

    typedef struct packed {
        asel_t a;
        bsel_t b;
        logic  neg;
        logic  first;
        logic  last;
        init_t init;
        dst_t  dst;
    } mac_op_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
        logic neg;
    } mac_ctrl_t;

    typedef struct packed {
        logic                      start;
        logic signed [ANGLE_W-1:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WORD_W-1:0] cos_val;
        logic signed [WORD_W-1:0] sin_val;
    } cordic_rsp_t;

    function automatic logic signed [CORD_W-1:0] atan_lookup(input logic [ATAN_IW-1:0] idx);
        logic signed [CORD_W-1:0] v;
        unique case (idx)
            5'd0:    v = 36'sd843314857;
            5'd1:    v = 36'sd497837830;
            5'd2:    v = 36'sd263043837;
            5'd3:    v = 36'sd133525159;
            5'd4:    v = 36'sd67021687;
            5'd5:    v = 36'sd33543516;
            5'd6:    v = 36'sd16775851;
            5'd7:    v = 36'sd8388437;
            5'd8:    v = 36'sd4194283;
            5'd9:    v = 36'sd2097149;
            5'd10:   v = 36'sd1048576;
            5'd11:   v = 36'sd524288;
            5'd12:   v = 36'sd262144;
            5'd13:   v = 36'sd131072;
            5'd14:   v = 36'sd65536;
            5'd15:   v = 36'sd32768;
            5'd16:   v = 36'sd16384;
            5'd17:   v = 36'sd8192;
            5'd18:   v = 36'sd4096;
            5'd19:   v = 36'sd2048;
            5'd20:   v = 36'sd1024;
            5'd21:   v = 36'sd512;
            5'd22:   v = 36'sd256;
            5'd23:   v = 36'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic mac_op_t mk_op(input asel_t a, input bsel_t b, input logic neg,
                                      input logic first, input logic last,
                                      input init_t init, input dst_t dst);
        mac_op_t op;
        op.a     = a;
        op.b     = b;
        op.neg   = neg;
        op.first = first;
        op.last  = last;
        op.init  = init;
        op.dst   = dst;
        return op;
    endfunction

    // The first four steps form the pivot terms, the other twelve the product.
    function automatic mac_op_t op_rom(input logic [STEP_W-1:0] step);
        mac_op_t op;
        unique case (step)
            4'd0:  op = mk_op(A_TX,  B_K0, 1'b1, 1'b1, 1'b0, I_TX,   D_G2);
            4'd1:  op = mk_op(A_TY,  B_K1, 1'b0, 1'b0, 1'b1, I_TX,   D_G2);
            4'd2:  op = mk_op(A_TY,  B_K2, 1'b1, 1'b1, 1'b0, I_TY,   D_G5);
            4'd3:  op = mk_op(A_TX,  B_K1, 1'b1, 1'b0, 1'b1, I_TY,   D_G5);
            4'd4:  op = mk_op(A_G00, B_M0, 1'b0, 1'b1, 1'b0, I_ZERO, D_N0);
            4'd5:  op = mk_op(A_G01, B_M3, 1'b0, 1'b0, 1'b1, I_ZERO, D_N0);
            4'd6:  op = mk_op(A_G00, B_M1, 1'b0, 1'b1, 1'b0, I_ZERO, D_N1);
            4'd7:  op = mk_op(A_G01, B_M4, 1'b0, 1'b0, 1'b1, I_ZERO, D_N1);
            4'd8:  op = mk_op(A_G00, B_M2, 1'b0, 1'b1, 1'b0, I_G2,   D_N2);
            4'd9:  op = mk_op(A_G01, B_M5, 1'b0, 1'b0, 1'b1, I_G2,   D_N2);
            4'd10: op = mk_op(A_G10, B_M0, 1'b0, 1'b1, 1'b0, I_ZERO, D_N3);
            4'd11: op = mk_op(A_G11, B_M3, 1'b0, 1'b0, 1'b1, I_ZERO, D_N3);
            4'd12: op = mk_op(A_G10, B_M1, 1'b0, 1'b1, 1'b0, I_ZERO, D_N4);
            4'd13: op = mk_op(A_G11, B_M4, 1'b0, 1'b0, 1'b1, I_ZERO, D_N4);
            4'd14: op = mk_op(A_G10, B_M2, 1'b0, 1'b1, 1'b0, I_G5,   D_N5);
            4'd15: op = mk_op(A_G11, B_M5, 1'b0, 1'b0, 1'b1, I_G5,   D_N5);
        endcase
        return op;
    endfunction

endpackage

/* hw/rtl/atc_mac.sv */
// ----------------------------------------------------------------------------
// Affine transform composer multiply-accumulate unit
// Shared signed multiplier with a registered product, rounding and accumulator.
// ----------------------------------------------------------------------------
module atc_mac #(
    parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  atc_pkg::mac_ctrl_t                     ctrl,
    input  logic signed [atc_pkg::WORD_W-1:0]      op_a,
    input  logic signed [atc_pkg::WORD_W-1:0]      op_b,
    input  logic signed [atc_pkg::ACC_W-1:0]       init,
    output logic signed [atc_pkg::ACC_W-1:0]       sum
);

    localparam logic signed [atc_pkg::ACC_W-1:0] HALF =
        atc_pkg::ACC_W'(1) <<< (FRAC_BITS - 1);

    logic signed [atc_pkg::ACC_W-1:0] prod;
    logic signed [atc_pkg::ACC_W-1:0] prod_reg;
    logic signed [atc_pkg::ACC_W-1:0] acc_reg;
    logic signed [atc_pkg::ACC_W-1:0] rounded;
    logic signed [atc_pkg::ACC_W-1:0] base;

    assign prod = atc_pkg::ACC_W'(op_a) * atc_pkg::ACC_W'(op_b);

    always_comb
    begin
        rounded = (prod_reg + HALF) >>> FRAC_BITS;
        base    = ctrl.first ? init : acc_reg;
        sum     = ctrl.neg ? (base - rounded) : (base + rounded);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctrl.mul_en)
            begin
                prod_reg <= prod;
            end
            if (ctrl.acc_en)
            begin
                acc_reg <= sum;
            end
        end
    end

endmodule

/* hw/rtl/atc_cordic.sv */
// ----------------------------------------------------------------------------
// Affine transform composer CORDIC unit
// Iterative rotation-mode CORDIC giving cosine and sine of a Q3.13 angle.
// ----------------------------------------------------------------------------
module atc_cordic #(
    parameter int FRAC_BITS    = atc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  atc_pkg::cordic_req_t  req,
    output atc_pkg::cordic_rsp_t  rsp
);

    localparam int CW = atc_pkg::CORD_W;
    localparam logic [atc_pkg::ATAN_IW-1:0] LAST_ITER =
        atc_pkg::ATAN_IW'(CORDIC_STEPS - 1);
    localparam logic signed [CW-1:0] HALF_OUT = CW'(1) <<< (29 - FRAC_BITS);

    logic signed [CW-1:0]            x_reg;
    logic signed [CW-1:0]            y_reg;
    logic signed [CW-1:0]            z_reg;
    logic                            neg_reg;
    logic                            busy_reg;
    logic                            busy_next;
    logic                            done_reg;
    logic                            done_next;
    logic [atc_pkg::ATAN_IW-1:0]     iter_reg;
    logic [atc_pkg::ATAN_IW-1:0]     iter_next;

    logic signed [CW-1:0] z_start;
    logic signed [CW-1:0] z_fold;
    logic                 neg_fold;
    logic signed [CW-1:0] x_shift;
    logic signed [CW-1:0] y_shift;
    logic signed [CW-1:0] atan_val;
    logic signed [CW-1:0] x_step;
    logic signed [CW-1:0] y_step;
    logic signed [CW-1:0] z_step;
    logic signed [CW-1:0] x_round;
    logic signed [CW-1:0] y_round;
    logic                 last_iter;

    always_comb
    begin
        z_start = CW'(req.angle) <<< 17;
        if (z_start > atc_pkg::HALF_PI_Q30)
        begin
            z_fold   = z_start - atc_pkg::PI_Q30;
            neg_fold = 1'b1;
        end
        else if (z_start < -atc_pkg::HALF_PI_Q30)
        begin
            z_fold   = z_start + atc_pkg::PI_Q30;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold   = z_start;
            neg_fold = 1'b0;
        end
    end

    always_comb
    begin
        x_shift  = x_reg >>> iter_reg;
        y_shift  = y_reg >>> iter_reg;
        atan_val = atc_pkg::atan_lookup(iter_reg);
        if (!z_reg[CW-1])
        begin
            x_step = x_reg - y_shift;
            y_step = y_reg + x_shift;
            z_step = z_reg - atan_val;
        end
        else
        begin
            x_step = x_reg + y_shift;
            y_step = y_reg - x_shift;
            z_step = z_reg + atan_val;
        end
    end

    assign last_iter = (iter_reg == LAST_ITER);

    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
        end
        else if (busy_reg)
        begin
            iter_next = iter_reg + 1'b1;
            if (last_iter)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= atc_pkg::CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= z_fold;
            neg_reg <= neg_fold;
        end
        else if (busy_reg)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
        end
    end

    always_comb
    begin
        x_round     = (x_reg + HALF_OUT) >>> (30 - FRAC_BITS);
        y_round     = (y_reg + HALF_OUT) >>> (30 - FRAC_BITS);
        rsp.done    = done_reg;
        rsp.cos_val = atc_pkg::WORD_W'(neg_reg ? -x_round : x_round);
        rsp.sin_val = atc_pkg::WORD_W'(neg_reg ? -y_round : y_round);
    end

endmodule

/* hw/rtl/affine_transform_composer.sv */
// ----------------------------------------------------------------------------
// Affine transform composer
// Holds a 2D affine matrix, pre-multiplies it by translate, rotate or scale, or loads identity.
// ----------------------------------------------------------------------------
// Rotate runs the CORDIC unit and then the multiply-accumulate steps, translate and
// scale only the steps, and load identity goes straight to the result beat.
// The shared multiplier runs 16 multiply-accumulate steps, each in MUL then ACC.
// One item at a time: the input is ready again once the result beat is loaded.
// Reset is asynchronous: the matrix returns to identity and no beat is pending.
`include "affine_transform_composer_assert.svh"

module affine_transform_composer #(
    parameter int FRAC_BITS    = atc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // off_x, off_y, angle, scale_x, scale_y
    input  logic [atc_pkg::IN_W-1:0]      s_axis_tdata,
    // func
    input  logic [atc_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // m00, m01, m02, m10, m11, m12
    output logic [atc_pkg::OUT_W-1:0]     m_axis_tdata,
    // overflow
    output logic                          m_axis_tuser
);

    localparam int W = atc_pkg::WORD_W;
    localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

    atc_pkg::state_t  state_reg;
    atc_pkg::state_t  state_next;
    atc_pkg::func_t   func_reg;
    atc_pkg::mac_op_t op;
    atc_pkg::mac_ctrl_t   mac_ctrl;
    atc_pkg::cordic_req_t cordic_req;
    atc_pkg::cordic_rsp_t cordic_rsp;

    logic [atc_pkg::STEP_W-1:0] step_reg;
    logic [atc_pkg::STEP_W-1:0] step_next;

    logic signed [W-1:0] tx_reg;
    logic signed [W-1:0] ty_reg;
    logic signed [W-1:0] sx_reg;
    logic signed [W-1:0] sy_reg;
    logic signed [W-1:0] cos_reg;
    logic signed [W-1:0] sin_reg;
    logic signed [atc_pkg::ACC_W-1:0] g2_reg;
    logic signed [atc_pkg::ACC_W-1:0] g5_reg;
    logic signed [W-1:0] res_reg [atc_pkg::NUM_ENT];
    logic signed [W-1:0] mat_reg [atc_pkg::NUM_ENT];
    logic                ov_reg;
    logic                out_ov_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic in_accept;
    logic commit;
    logic in_rotate;
    logic cordic_wait;
    logic last_acc;
    logic ident_done;
    logic signed [W-1:0] op_a;
    logic signed [W-1:0] op_b;
    logic signed [W-1:0] g00;
    logic signed [W-1:0] g01;
    logic signed [W-1:0] g10;
    logic signed [W-1:0] g11;
    logic signed [W-1:0] k0;
    logic signed [W-1:0] k1;
    logic signed [W-1:0] k2;
    logic signed [atc_pkg::ACC_W-1:0] init_val;
    logic signed [atc_pkg::ACC_W-1:0] mac_sum;
    logic signed [W-1:0] sat_val;
    logic                sat_ovf;

    assign op = atc_pkg::op_rom(step_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            atc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (atc_pkg::func_t'(s_axis_tuser))
                        atc_pkg::FUNC_ROTATE:   state_next = atc_pkg::ST_CORDIC;
                        atc_pkg::FUNC_IDENTITY: state_next = atc_pkg::ST_DONE;
                        default:                state_next = atc_pkg::ST_MUL;
                    endcase
                end
            end
            atc_pkg::ST_CORDIC:
            begin
                if (cordic_rsp.done)
                begin
                    state_next = atc_pkg::ST_MUL;
                end
            end
            atc_pkg::ST_MUL:
            begin
                state_next = atc_pkg::ST_ACC;
            end
            atc_pkg::ST_ACC:
            begin
                state_next = (step_reg == atc_pkg::LAST_STEP) ? atc_pkg::ST_DONE
                                                              : atc_pkg::ST_MUL;
            end
            atc_pkg::ST_DONE:
            begin
                if (commit)
                begin
                    state_next = atc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = atc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready     = (state_reg == atc_pkg::ST_IDLE);
        in_accept         = s_axis_tvalid && s_axis_tready;
        in_rotate         = (atc_pkg::func_t'(s_axis_tuser) == atc_pkg::FUNC_ROTATE);
        commit            = (state_reg == atc_pkg::ST_DONE)
                            && (!out_valid_reg || m_axis_tready);
        mac_ctrl.mul_en   = (state_reg == atc_pkg::ST_MUL);
        mac_ctrl.acc_en   = (state_reg == atc_pkg::ST_ACC);
        mac_ctrl.first    = op.first;
        mac_ctrl.neg      = op.neg;
        cordic_req.start  = in_accept && in_rotate;
        cordic_req.angle  = s_axis_tdata[79:64];
        step_next         = step_reg;
        if (in_accept)
        begin
            step_next = '0;
        end
        else if (state_reg == atc_pkg::ST_ACC)
        begin
            step_next = step_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        g00 = ONE;
        g01 = '0;
        g10 = '0;
        g11 = ONE;
        k0  = '0;
        k1  = '0;
        k2  = '0;
        unique case (func_reg)
            atc_pkg::FUNC_ROTATE:
            begin
                g00 = cos_reg;
                g01 = -sin_reg;
                g10 = sin_reg;
                g11 = cos_reg;
                k0  = cos_reg;
                k1  = sin_reg;
                k2  = cos_reg;
            end
            atc_pkg::FUNC_SCALE:
            begin
                g00 = sx_reg;
                g11 = sy_reg;
                k0  = sx_reg;
                k2  = sy_reg;
            end
            default:
            begin
                g00 = ONE;
            end
        endcase
    end

    always_comb
    begin
        unique case (op.a)
            atc_pkg::A_TX:  op_a = tx_reg;
            atc_pkg::A_TY:  op_a = ty_reg;
            atc_pkg::A_G00: op_a = g00;
            atc_pkg::A_G01: op_a = g01;
            atc_pkg::A_G10: op_a = g10;
            atc_pkg::A_G11: op_a = g11;
            default:        op_a = '0;
        endcase
        unique case (op.b)
            atc_pkg::B_K0: op_b = k0;
            atc_pkg::B_K1: op_b = k1;
            atc_pkg::B_K2: op_b = k2;
            atc_pkg::B_M0: op_b = mat_reg[0];
            atc_pkg::B_M1: op_b = mat_reg[1];
            atc_pkg::B_M2: op_b = mat_reg[2];
            atc_pkg::B_M3: op_b = mat_reg[3];
            atc_pkg::B_M4: op_b = mat_reg[4];
            atc_pkg::B_M5: op_b = mat_reg[5];
            default:       op_b = '0;
        endcase
        unique case (op.init)
            atc_pkg::I_TX: init_val = atc_pkg::ACC_W'(tx_reg);
            atc_pkg::I_TY: init_val = atc_pkg::ACC_W'(ty_reg);
            atc_pkg::I_G2: init_val = g2_reg;
            atc_pkg::I_G5: init_val = g5_reg;
            default:       init_val = '0;
        endcase
    end

    always_comb
    begin
        sat_ovf = 1'b0;
        sat_val = W'(mac_sum);
        if (mac_sum > atc_pkg::SAT_MAX)
        begin
            sat_ovf = 1'b1;
            sat_val = W'(atc_pkg::SAT_MAX);
        end
        else if (mac_sum < atc_pkg::SAT_MIN)
        begin
            sat_ovf = 1'b1;
            sat_val = W'(atc_pkg::SAT_MIN);
        end
    end

    atc_mac #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (op_a),
        .op_b  (op_b),
        .init  (init_val),
        .sum   (mac_sum)
    );

    atc_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atc_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            ov_reg        <= 1'b0;
            out_ov_reg    <= 1'b0;
            mat_reg[0]    <= ONE;
            mat_reg[1]    <= '0;
            mat_reg[2]    <= '0;
            mat_reg[3]    <= '0;
            mat_reg[4]    <= ONE;
            mat_reg[5]    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                ov_reg <= 1'b0;
            end
            else if (mac_ctrl.acc_en && op.last && sat_ovf && op.dst != atc_pkg::D_G2
                     && op.dst != atc_pkg::D_G5)
            begin
                ov_reg <= 1'b1;
            end
            if (commit)
            begin
                out_ov_reg <= ov_reg;
                for (int i = 0; i < atc_pkg::NUM_ENT; i++)
                begin
                    mat_reg[i] <= res_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= atc_pkg::func_t'(s_axis_tuser);
            tx_reg   <= s_axis_tdata[31:0];
            ty_reg   <= s_axis_tdata[63:32];
            sx_reg   <= s_axis_tdata[111:80];
            sy_reg   <= s_axis_tdata[143:112];
            if (atc_pkg::func_t'(s_axis_tuser) == atc_pkg::FUNC_IDENTITY)
            begin
                res_reg[0] <= ONE;
                res_reg[1] <= '0;
                res_reg[2] <= '0;
                res_reg[3] <= '0;
                res_reg[4] <= ONE;
                res_reg[5] <= '0;
            end
        end
        if (cordic_rsp.done)
        begin
            cos_reg <= cordic_rsp.cos_val;
            sin_reg <= cordic_rsp.sin_val;
        end
        if (mac_ctrl.acc_en && op.last)
        begin
            unique case (op.dst)
                atc_pkg::D_G2: g2_reg     <= mac_sum;
                atc_pkg::D_G5: g5_reg     <= mac_sum;
                atc_pkg::D_N0: res_reg[0] <= sat_val;
                atc_pkg::D_N1: res_reg[1] <= sat_val;
                atc_pkg::D_N2: res_reg[2] <= sat_val;
                atc_pkg::D_N3: res_reg[3] <= sat_val;
                atc_pkg::D_N4: res_reg[4] <= sat_val;
                atc_pkg::D_N5: res_reg[5] <= sat_val;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ov_reg;
    assign m_axis_tdata  = {mat_reg[5], mat_reg[4], mat_reg[3],
                            mat_reg[2], mat_reg[1], mat_reg[0]};

    assign cordic_wait = (state_reg == atc_pkg::ST_CORDIC);
    assign last_acc    = (state_reg == atc_pkg::ST_ACC) && (step_reg == atc_pkg::LAST_STEP);
    assign ident_done  = (state_reg == atc_pkg::ST_DONE)
                         && (func_reg == atc_pkg::FUNC_IDENTITY);

    `ATC_ASSERT_NEXT(a_commit_shows_beat, clk, rst_n, commit, m_axis_tvalid)
    `ATC_ASSERT_SAME(a_cordic_done_waited, clk, rst_n, cordic_rsp.done, cordic_wait)
    `ATC_ASSERT_NEXT(a_last_step_done, clk, rst_n, last_acc, state_reg == atc_pkg::ST_DONE)
    `ATC_ASSERT_SAME(a_identity_no_ovf, clk, rst_n, ident_done, !ov_reg)

endmodule

/* test/affine_transform_composer_test.sv */
// ----------------------------------------------------------------------------
// Affine transform composer testbench
// Drives translate, rotate, scale and identity beats with random gaps on both
// sides, predicts every updated matrix in fixed point and checks each result.
// ----------------------------------------------------------------------------
module affine_transform_composer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = atc_pkg::FRAC_BITS_DEF;
    localparam int NSTEP = atc_pkg::CORDIC_STEPS_DEF;
    localparam longint ONE = 64'sd1 << FB;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] pad;
        logic signed [31:0] sy;
        logic signed [31:0] sx;
        logic signed [15:0] ang;
        logic signed [31:0] oy;
        logic signed [31:0] ox;
    } cmd_t;

    typedef struct {
        atc_pkg::func_t op;
        cmd_t d;
    } beat_t;

    typedef struct {
        logic [atc_pkg::OUT_W-1:0] ent;
        logic ovf;
    } mat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [atc_pkg::IN_W-1:0] s_axis_tdata = '0;
    logic [atc_pkg::FUNC_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [atc_pkg::OUT_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    beat_t pending_beats[$];
    mat_t expected_mats[$];
    longint held[6];
    int errors = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int hold_off = 0;
    int watch = 0;
    int results_seen = 0;
    logic in_fire_q = 1'b0;
    logic out_fire_q = 1'b0;

    affine_transform_composer dut (.*);

    always #6 clk = ~clk;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fxmul(longint a, longint b);
        return asr(a * b + (64'sd1 <<< (FB - 1)), FB);
    endfunction

    function automatic longint arctan_q30(int i);
        longint t[24] = '{843314857, 497837830, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
        return t[i];
    endfunction

    task automatic sincos(input longint a, output longint c, output longint s);
        longint z, x, y, nx;
        bit flip;
        z = a * 131072;
        x = 652032875;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1686629713)
        begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end
        else if (z < -64'sd1686629713)
        begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < NSTEP && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - asr(y, i);
                y = y + asr(x, i);
                z -= arctan_q30(i);
            end
            else
            begin
                nx = x + asr(y, i);
                y = y - asr(x, i);
                z += arctan_q30(i);
            end
            x = nx;
        end
        x = asr(x + (64'sd1 <<< (29 - FB)), 30 - FB);
        y = asr(y + (64'sd1 <<< (29 - FB)), 30 - FB);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic compose_matrix(input beat_t b, output mat_t r);
        longint g[6], n[6], c, s, tx, ty, sx, sy;
        bit ov;
        tx = b.d.ox;
        ty = b.d.oy;
        sx = b.d.sx;
        sy = b.d.sy;
        ov = 1'b0;
        if (b.op == atc_pkg::FUNC_IDENTITY)
        begin
            held = '{ONE, 0, 0, 0, ONE, 0};
        end
        else
        begin
            case (b.op)
                atc_pkg::FUNC_TRANSLATE: g = '{ONE, 0, tx, 0, ONE, ty};
                atc_pkg::FUNC_ROTATE:
                begin
                    sincos(longint'(b.d.ang), c, s);
                    g = '{c, -s, tx - fxmul(tx, c) + fxmul(ty, s),
                          s, c, ty - fxmul(ty, c) - fxmul(tx, s)};
                end
                default: g = '{sx, 0, tx - fxmul(tx, sx), 0, sy, ty - fxmul(ty, sy)};
            endcase
            for (int r0 = 0; r0 < 2; r0++)
                for (int j = 0; j < 3; j++)
                    n[3*r0+j] = fxmul(g[3*r0], held[j]) + fxmul(g[3*r0+1], held[3+j])
                                + (j == 2 ? g[3*r0+2] : 0);
            for (int k = 0; k < 6; k++)
            begin
                if (n[k] > 64'sd2147483647)
                begin
                    n[k] = 64'sd2147483647;
                    ov = 1'b1;
                end
                else if (n[k] < -64'sd2147483648)
                begin
                    n[k] = -64'sd2147483648;
                    ov = 1'b1;
                end
                held[k] = n[k];
            end
        end
        for (int k = 0; k < 6; k++)
            r.ent[32*k +: 32] = held[k][31:0];
        r.ovf = ov;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return 32'(int'($urandom_range(0, 8 * ONE)) - 4 * int'(ONE));
        endcase
    endfunction

    function automatic beat_t make_beat(atc_pkg::func_t op, logic [31:0] ox,
                                        logic [31:0] oy, logic [15:0] ang,
                                        logic [31:0] sx, logic [31:0] sy);
        beat_t b;
        b.op = op;
        b.d = '{16'd0, sy, sx, ang, oy, ox};
        return b;
    endfunction

    initial
    begin
        beat_t b;
        held = '{ONE, 0, 0, 0, ONE, 0};
        pending_beats.push_back(make_beat(atc_pkg::FUNC_TRANSLATE, 32'h7FFF_FFFF,
                                          32'h8000_0000, 0, 0, 0));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_TRANSLATE, 32'h7FFF_FFFF,
                                          32'h8000_0000, 0, 0, 0));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_IDENTITY, '1, '1, '1, '1, '1));
        for (int a = -32768; a < 32768; a += 8192)
            pending_beats.push_back(make_beat(atc_pkg::FUNC_ROTATE, 32'h0002_0000,
                                              32'hFFFF_0000, 16'(a), 0, 0));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_ROTATE, 0, 0, 16'sd25736, 0, 0));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_ROTATE, 0, 0, -16'sd25736, 0, 0));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_ROTATE, 0, 0, 16'sd12868, 0, 0));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_ROTATE, 0, 0, 16'h7FFF, 0, 0));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_SCALE, 32'h0001_0000,
                                          32'h0003_0000, 0, 32'h7FFF_FFFF,
                                          32'h8000_0000));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_SCALE, 0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_IDENTITY, 0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_SCALE, 32'h8000_0000,
                                          32'h7FFF_FFFF, 0, 32'hFFFF_0000,
                                          32'h0000_8000));
        pending_beats.push_back(make_beat(atc_pkg::FUNC_IDENTITY, 0, 0, 0, 0, 0));
        for (int i = 0; i < 850; i++)
        begin
            b.op = atc_pkg::func_t'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 8 && b.op == atc_pkg::FUNC_IDENTITY)
                b.op = atc_pkg::FUNC_ROTATE;
            if ($urandom_range(0, 19) == 0)
                b.op = atc_pkg::FUNC_IDENTITY;
            b.d.pad = '0;
            b.d.ox = rand_word();
            b.d.oy = rand_word();
            b.d.sx = ($urandom_range(0, 3) == 0) ? rand_word()
                     : 32'(int'($urandom_range(0, 2 * ONE)) - int'(ONE) / 2);
            b.d.sy = ($urandom_range(0, 3) == 0) ? rand_word()
                     : 32'(int'($urandom_range(0, 2 * ONE)) - int'(ONE) / 2);
            b.d.ang = $urandom;
            pending_beats.push_back(b);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire_q)
            begin
                if (pending_beats.size() != 0)
                    void'(pending_beats.pop_front());
                send_wait <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
                s_axis_tvalid <= 1'b0;
            end
            else if (!s_axis_tvalid)
            begin
                if (send_wait > 0)
                begin
                    send_wait <= send_wait - 1;
                end
                else if (pending_beats.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= pending_beats[0].op;
                    s_axis_tdata <= pending_beats[0].d;
                end
            end
            if (results_seen == 300 && hold_off == 0)
                hold_off <= 400;
            if (hold_off > 1)
            begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end
            else if (out_fire_q)
            begin
                recv_wait <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end
            else if (!m_axis_tready)
            begin
                if (recv_wait > 0)
                    recv_wait <= recv_wait - 1;
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        mat_t e;
        in_fire_q <= s_axis_tvalid && s_axis_tready;
        out_fire_q <= m_axis_tvalid && m_axis_tready;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                watch <= 0;
            else
                watch <= watch + 1;
            if (s_axis_tvalid && s_axis_tready)
            begin
                beat_t b;
                b.op = atc_pkg::func_t'(s_axis_tuser);
                b.d = s_axis_tdata;
                compose_matrix(b, e);
                expected_mats.push_back(e);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_mats.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result %h %b", $time, m_axis_tdata,
                             m_axis_tuser);
                end
                else
                begin
                    e = expected_mats.pop_front();
                    for (int k = 0; k < 6; k++)
                        if (m_axis_tdata[32*k +: 32] !== e.ent[32*k +: 32])
                        begin
                            errors++;
                            $display("%0t entry %0d expected %h actual %h", $time, k,
                                     e.ent[32*k +: 32], m_axis_tdata[32*k +: 32]);
                        end
                    if (m_axis_tuser !== e.ovf)
                    begin
                        errors++;
                        $display("%0t overflow expected %b actual %b", $time, e.ovf,
                                 m_axis_tuser);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_mats.size() != 0)
        begin
            @(posedge clk);
            if (watch >= WATCH_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
        repeat (60) @(posedge clk);
        if (errors == 0 && expected_mats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
